FILE: rtl/ord_pkg.sv
// shared types and constants for the overwriting ring deque
package ord_pkg;

  localparam int CNT_W = 5;
  localparam int PTR_W = 5;
  localparam int SIZE_LIMIT = 31;
  localparam logic [CNT_W-1:0] SIZE_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_PUT        = 2'd0,
    OP_GET_NEWEST = 2'd1,
    OP_GET_OLDEST = 2'd2
  } op_t;

  typedef struct packed {
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] fill;
  } res_info_t;

endpackage

FILE: rtl/ord_mem.sv
// slot storage with one write port and one registered read port
module ord_mem #(
  parameter int WORDS = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  ord_pkg::mem_req_t     req,
  input  logic [DATA_WIDTH-1:0] wr_data,
  output logic [DATA_WIDTH-1:0] rd_data
);

  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [DATA_WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr[AW-1:0]];
    end
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= wr_data;
    end
  end

endmodule

FILE: rtl/ord_ctrl.sv
// head and count pointers, size register and slot address decode
module ord_ctrl #(
  parameter int SIZE_MAX = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [ord_pkg::CNT_W-1:0]   cfg_wr_data,
  input  logic                        go,
  input  ord_pkg::op_t                op,
  input  logic                        rm,
  output ord_pkg::mem_req_t           req,
  output ord_pkg::res_info_t          info
);

  localparam logic [ord_pkg::CNT_W-1:0] SIZE_CAP = ord_pkg::CNT_W'(SIZE_MAX);

  logic [ord_pkg::CNT_W-1:0] ring_size;
  logic [ord_pkg::PTR_W-1:0] head;
  logic [ord_pkg::PTR_W-1:0] head_next;
  logic [ord_pkg::CNT_W-1:0] count;
  logic [ord_pkg::CNT_W-1:0] count_next;
  logic [ord_pkg::CNT_W-1:0] size_used;
  logic [ord_pkg::PTR_W-1:0] tail;
  logic [ord_pkg::PTR_W-1:0] newest;
  logic [ord_pkg::PTR_W-1:0] head_inc;
  logic                      hit;

  function automatic logic [ord_pkg::PTR_W-1:0] wrap_add(
    input logic [ord_pkg::PTR_W-1:0] a,
    input logic [ord_pkg::CNT_W-1:0] b,
    input logic [ord_pkg::CNT_W-1:0] sz
  );
    logic [ord_pkg::PTR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, sz}) begin
      s = s - {1'b0, sz};
    end
    return s[ord_pkg::PTR_W-1:0];
  endfunction

  always_comb begin
    if (ring_size == '0) begin
      size_used = ord_pkg::CNT_W'(1);
    end else if (ring_size > SIZE_CAP) begin
      size_used = SIZE_CAP;
    end else begin
      size_used = ring_size;
    end
  end

  assign tail     = wrap_add(head, count, size_used);
  assign newest   = wrap_add(head, count - ord_pkg::CNT_W'(1), size_used);
  assign head_inc = wrap_add(head, ord_pkg::CNT_W'(1), size_used);

  always_comb begin
    head_next   = head;
    count_next  = count;
    hit         = 1'b0;
    req.wr_en   = 1'b0;
    req.wr_addr = tail;
    req.rd_addr = head;
    unique case (op)
      ord_pkg::OP_PUT: begin
        req.wr_en = go;
        if (count >= size_used) begin
          hit         = 1'b1;
          req.wr_addr = head;
          head_next   = head_inc;
        end else begin
          count_next = count + ord_pkg::CNT_W'(1);
        end
      end
      ord_pkg::OP_GET_NEWEST: begin
        req.rd_addr = newest;
        if (count != '0) begin
          hit = 1'b1;
          if (rm) begin
            count_next = count - ord_pkg::CNT_W'(1);
          end
        end
      end
      ord_pkg::OP_GET_OLDEST: begin
        if (count != '0) begin
          hit = 1'b1;
          if (rm) begin
            head_next  = head_inc;
            count_next = count - ord_pkg::CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
    req.rd_en = go && hit;
  end

  assign info.hit  = hit;
  assign info.fill = count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size <= ord_pkg::SIZE_RESET;
      head      <= '0;
      count     <= '0;
    end else if (cfg_wr_en) begin
      ring_size <= cfg_wr_data;
      head      <= '0;
      count     <= '0;
    end else if (go) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= size_used) else $error("held count exceeds size in use");

  a_head_in_range: assert property (@(posedge clk) disable iff (rst)
    head < ord_pkg::PTR_W'(size_used)) else $error("head outside size in use");

  a_cfg_empties: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> (count == '0) && (head == '0))
    else $error("size write did not empty the ring");

endmodule

FILE: rtl/overwriting_ring_deque.sv
// top level of the overwriting ring deque: input stage, control, slots, result stage
//
//   channel   signals                                   dir
//   in        in_valid in_stall opcode remove value      in
//   res       res_valid res_stall out_valid out_value    out
//             fill_count
//   cfg       cfg_wr_en cfg_wr_data                      in
//
// one item per cycle unless stalled; a result is registered after the input stage
// the slot memory read and pointer update happen on the edge into the result stage
// reset empties the ring; the size register resets to 16, used up to DEPTH
// while a result waits under res_stall, one more item is taken into the input stage
module overwriting_ring_deque #(
  parameter int DEPTH = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [ord_pkg::CNT_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  opcode,
  input  logic                        remove,
  input  logic [DATA_WIDTH-1:0]       value,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic                        out_valid,
  output logic [DATA_WIDTH-1:0]       out_value,
  output logic [ord_pkg::CNT_W-1:0]   fill_count
);

  localparam int SizeMax = (DEPTH < ord_pkg::SIZE_LIMIT) ? DEPTH : ord_pkg::SIZE_LIMIT;

  logic                      s1_v;
  ord_pkg::op_t              s1_op;
  logic                      s1_rm;
  logic [DATA_WIDTH-1:0]     s1_val;
  logic                      adv;
  logic                      accept;
  logic                      res_hit;
  logic [ord_pkg::CNT_W-1:0] res_fill;
  logic [DATA_WIDTH-1:0]     rd_data;
  ord_pkg::mem_req_t         req;
  ord_pkg::res_info_t        info;

  assign adv      = s1_v && (!res_valid || !res_stall);
  assign in_stall = s1_v && res_valid && res_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (accept) begin
      s1_v <= 1'b1;
    end else if (adv) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op  <= ord_pkg::op_t'(opcode);
      s1_rm  <= remove;
      s1_val <= value;
    end
  end

  ord_ctrl #(
    .SIZE_MAX(SizeMax)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .go         (adv),
    .op         (s1_op),
    .rm         (s1_rm),
    .req        (req),
    .info       (info)
  );

  ord_mem #(
    .WORDS     (SizeMax),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_mem (
    .clk    (clk),
    .req    (req),
    .wr_data(s1_val),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_hit  <= info.hit;
      res_fill <= info.fill;
    end
  end

  assign out_valid  = res_hit;
  assign out_value  = res_hit ? rd_data : '0;
  assign fill_count = res_fill;

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_v) else $error("accepted item lost from input stage");

  a_stall_needs_both: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> s1_v) else $error("input stage emptied while stalled");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(out_valid) && $stable(out_value)
      && $stable(fill_count)) else $error("stalled result changed");

endmodule
